/* rtl/esp_pkg.sv */
`timescale 1ns / 1ps
package esp_pkg;

	localparam int COORD_FRAC_BITS_DEF = 4;
	localparam int CORDIC_STEPS_DEF    = 16;
	localparam int ATAN_LEN            = 24;
	localparam int STEP_W              = $clog2(ATAN_LEN);

	localparam int REG_W   = 48;
	localparam int FLD_W   = 16;
	localparam int COEF_W  = 24;
	localparam int OFF_W   = 32;
	localparam int TRIG_W  = 28;
	localparam int CORD_W  = 34;
	localparam int MUL_W   = 28;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int CIDX_W  = 3;
	localparam int MAT_OPS = 14;

	localparam logic [CIDX_W-1:0] REG_MOVE  = 3'd0;
	localparam logic [CIDX_W-1:0] REG_ANGLE = 3'd1;
	localparam logic [CIDX_W-1:0] REG_SCALE = 3'd2;
	localparam logic [CIDX_W-1:0] REG_PIVOT = 3'd3;

	localparam logic [REG_W-1:0] SCALE_RESET = 48'h1000_1000_1000;
	localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd65536;

	localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [19:0] DEG_TO_RAD = 20'sd292818;
	localparam logic signed [17:0] TURN    = 18'sd23040;
	localparam logic signed [17:0] HALF    = 18'sd11520;
	localparam logic signed [17:0] QUARTER = 18'sd5760;

	// trig register file slots
	localparam logic [2:0] TRIG_SA = 3'd0;
	localparam logic [2:0] TRIG_CA = 3'd1;
	localparam logic [2:0] TRIG_SB = 3'd2;
	localparam logic [2:0] TRIG_CB = 3'd3;
	localparam logic [2:0] TRIG_SC = 3'd4;
	localparam logic [2:0] TRIG_CC = 3'd5;
	localparam logic [2:0] TRIG_T0 = 3'd6;
	localparam logic [2:0] TRIG_T1 = 3'd7;

	typedef struct packed {
		logic [REG_W-1:0] move;
		logic [REG_W-1:0] angle;
		logic [REG_W-1:0] scale;
		logic [REG_W-1:0] pivot;
	} cfg_regs_t;

	typedef struct packed {
		logic [8:0][COEF_W-1:0] a;
		logic [2:0][OFF_W-1:0]  b;
	} coef_t;

	typedef enum logic [3:0] {
		DR_IDLE,
		DR_REDUCE,
		DR_ZINIT,
		DR_ROT,
		DR_SAVE,
		DR_MAT_MUL,
		DR_MAT_ACC,
		DR_ROW_MUL,
		DR_ROW_ACC,
		DR_ROW_END
	} dr_state_t;

	typedef enum logic [1:0] {
		ACC_SET,
		ACC_ADD,
		ACC_SUB,
		ACC_NEG
	} acc_mode_t;

	typedef struct packed {
		logic [2:0] src_a;
		logic [2:0] src_b;
		logic       to_trig;
		logic [3:0] dst;
		acc_mode_t  mode;
	} mat_op_t;

	function automatic logic signed [FLD_W-1:0] fld(input logic [REG_W-1:0] r,
		input logic [1:0] idx);
		logic signed [FLD_W-1:0] v;
		v = '0;
		case (idx)
			2'd0:    v = r[15:0];
			2'd1:    v = r[31:16];
			2'd2:    v = r[47:32];
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [CORD_W-1:0] atan_q30(input logic [STEP_W-1:0] i);
		logic signed [CORD_W-1:0] v;
		v = '0;
		case (i)
			5'd0:    v = 34'sd843314856;
			5'd1:    v = 34'sd497837829;
			5'd2:    v = 34'sd263043836;
			5'd3:    v = 34'sd133525158;
			5'd4:    v = 34'sd67021686;
			5'd5:    v = 34'sd33543515;
			5'd6:    v = 34'sd16775850;
			5'd7:    v = 34'sd8388437;
			5'd8:    v = 34'sd4194282;
			5'd9:    v = 34'sd2097149;
			5'd10:   v = 34'sd1048575;
			5'd11:   v = 34'sd524287;
			5'd12:   v = 34'sd262143;
			5'd13:   v = 34'sd131071;
			5'd14:   v = 34'sd65535;
			5'd15:   v = 34'sd32767;
			5'd16:   v = 34'sd16383;
			5'd17:   v = 34'sd8191;
			5'd18:   v = 34'sd4095;
			5'd19:   v = 34'sd2047;
			5'd20:   v = 34'sd1023;
			5'd21:   v = 34'sd511;
			5'd22:   v = 34'sd255;
			5'd23:   v = 34'sd127;
			default: v = '0;
		endcase
		return v;
	endfunction

	// rotation matrix product list; rm[3] = sc is loaded directly
	function automatic mat_op_t mat_op(input logic [3:0] i);
		mat_op_t o;
		o = '{TRIG_SA, TRIG_SA, 1'b0, 4'd0, ACC_SET};
		case (i)
			4'd0:    o = '{TRIG_CB, TRIG_SC, 1'b1, 4'd0, ACC_SET};
			4'd1:    o = '{TRIG_SB, TRIG_SC, 1'b1, 4'd1, ACC_SET};
			4'd2:    o = '{TRIG_CB, TRIG_CC, 1'b0, 4'd0, ACC_SET};
			4'd3:    o = '{TRIG_SB, TRIG_SA, 1'b0, 4'd1, ACC_SET};
			4'd4:    o = '{TRIG_T0, TRIG_CA, 1'b0, 4'd1, ACC_SUB};
			4'd5:    o = '{TRIG_T0, TRIG_SA, 1'b0, 4'd2, ACC_SET};
			4'd6:    o = '{TRIG_SB, TRIG_CA, 1'b0, 4'd2, ACC_ADD};
			4'd7:    o = '{TRIG_CC, TRIG_CA, 1'b0, 4'd4, ACC_SET};
			4'd8:    o = '{TRIG_CC, TRIG_SA, 1'b0, 4'd5, ACC_NEG};
			4'd9:    o = '{TRIG_SB, TRIG_CC, 1'b0, 4'd6, ACC_NEG};
			4'd10:   o = '{TRIG_T1, TRIG_CA, 1'b0, 4'd7, ACC_SET};
			4'd11:   o = '{TRIG_CB, TRIG_SA, 1'b0, 4'd7, ACC_ADD};
			4'd12:   o = '{TRIG_CB, TRIG_CA, 1'b0, 4'd8, ACC_SET};
			4'd13:   o = '{TRIG_T1, TRIG_SA, 1'b0, 4'd8, ACC_SUB};
			default: o = '{TRIG_SA, TRIG_SA, 1'b0, 4'd0, ACC_SET};
		endcase
		return o;
	endfunction

endpackage

/* rtl/esp_derive.sv */
`timescale 1ns / 1ps
module esp_derive #(
	parameter int COORD_FRAC_BITS = esp_pkg::COORD_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = esp_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  esp_pkg::cfg_regs_t regs,
	output logic              busy,
	output esp_pkg::coef_t    coef
);
	import esp_pkg::*;

	localparam int NSTEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

	dr_state_t state_q, state_nxt;

	logic [1:0]        ang_q;
	logic [STEP_W-1:0] step_q;
	logic [3:0]        opi_q;
	logic [1:0]        row_q;
	logic [2:0]        rop_q;

	logic signed [14:0]       r_q;
	logic                     flip_q;
	logic signed [CORD_W-1:0] x_q, y_q, z_q;
	logic signed [TRIG_W-1:0] trig_q [8];
	logic signed [TRIG_W-1:0] rm_q [9];
	logic signed [PROD_W-1:0] prod_q;
	logic signed [46:0]       rp_q;
	logic signed [47:0]       d_q;
	logic signed [63:0]       kd_q;
	coef_t                    coef_q;

	// angle reduction
	logic signed [FLD_W-1:0] deg;
	logic signed [17:0]      m1, m2, red_r;
	logic                    red_flip;

	always_comb begin
		deg = fld(regs.angle, ang_q);
		m1  = 18'(deg);
		if (m1 < 0) begin
			m1 = m1 + TURN;
		end else if (m1 >= TURN) begin
			m1 = m1 - TURN;
		end
		if (m1 < 0) begin
			m1 = m1 + TURN;
		end
		m2 = (m1 >= HALF) ? m1 - TURN : m1;
		red_flip = 1'b0;
		red_r    = m2;
		priority if (m2 > QUARTER) begin
			red_r    = m2 - HALF;
			red_flip = 1'b1;
		end else if (m2 < -QUARTER) begin
			red_r    = m2 + HALF;
			red_flip = 1'b1;
		end else begin
			red_r = m2;
		end
	end

	// CORDIC step
	logic signed [CORD_W-1:0] dx, dy, at;
	assign dx = y_q >>> step_q;
	assign dy = x_q >>> step_q;
	assign at = atan_q30(step_q);

	logic signed [CORD_W-1:0] cs_w, sn_w;
	logic signed [TRIG_W-1:0] cs_v, sn_v;
	assign cs_w = (x_q + 34'sd32) >>> 6;
	assign sn_w = (y_q + 34'sd32) >>> 6;
	assign cs_v = flip_q ? -cs_w[TRIG_W-1:0] : cs_w[TRIG_W-1:0];
	assign sn_v = flip_q ? -sn_w[TRIG_W-1:0] : sn_w[TRIG_W-1:0];

	// shared multiplier operands
	mat_op_t                  mop;
	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [FLD_W-1:0]  k_row, mv_row, pv_row, pv_col;
	logic [3:0]               ridx;
	logic [1:0]               col;

	assign mop    = mat_op(opi_q);
	assign k_row  = fld(regs.scale, row_q);
	assign mv_row = fld(regs.move, row_q);
	assign pv_row = fld(regs.pivot, row_q);
	assign col    = (rop_q >= 3'd3) ? 2'(rop_q - 3'd3) : rop_q[1:0];
	assign pv_col = fld(regs.pivot, col);
	assign ridx   = 4'(row_q) * 4'd3 + 4'(col);

	always_comb begin
		busy  = (state_q != DR_IDLE);
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			DR_MAT_MUL: begin
				mul_a = trig_q[mop.src_a];
				mul_b = trig_q[mop.src_b];
			end
			DR_ROW_MUL: begin
				priority if (rop_q < 3'd3) begin
					mul_a = MUL_W'(k_row);
					mul_b = rm_q[ridx];
				end else if (rop_q < 3'd6) begin
					mul_a = rm_q[ridx];
					mul_b = MUL_W'(pv_col);
				end else if (rop_q == 3'd6) begin
					mul_a = MUL_W'(k_row);
					mul_b = $signed({7'd0, d_q[20:0]});
				end else begin
					mul_a = MUL_W'(k_row);
					mul_b = MUL_W'($signed(d_q[47:21]));
				end
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			DR_IDLE:    if (start) state_nxt = DR_REDUCE;
			DR_REDUCE:  state_nxt = DR_ZINIT;
			DR_ZINIT:   state_nxt = DR_ROT;
			DR_ROT:     if (step_q == LAST_STEP) state_nxt = DR_SAVE;
			DR_SAVE:    state_nxt = (ang_q == 2'd2) ? DR_MAT_MUL : DR_REDUCE;
			DR_MAT_MUL: state_nxt = DR_MAT_ACC;
			DR_MAT_ACC: state_nxt = (opi_q == 4'(MAT_OPS - 1)) ? DR_ROW_MUL : DR_MAT_MUL;
			DR_ROW_MUL: state_nxt = DR_ROW_ACC;
			DR_ROW_ACC: state_nxt = (rop_q == 3'd7) ? DR_ROW_END : DR_ROW_MUL;
			DR_ROW_END: state_nxt = (row_q == 2'd2) ? DR_IDLE : DR_ROW_MUL;
			default:    state_nxt = DR_IDLE;
		endcase
	end

	// accumulate-phase values
	logic signed [PROD_W-1:0] mat_w, cr_w;
	logic signed [TRIG_W-1:0] mat_v;
	logic signed [COEF_W-1:0] cr_sat;
	logic signed [46:0]       rp_sum;
	logic signed [47:0]       d_nxt;
	logic signed [63:0]       bw;
	logic signed [OFF_W-1:0]  b_sat;

	always_comb begin
		mat_w  = (prod_q + (56'sd1 <<< 23)) >>> 24;
		mat_v  = mat_w[TRIG_W-1:0];
		cr_w   = (prod_q + (56'sd1 <<< 19)) >>> 20;
		priority if (cr_w > 56'sd8388607) begin
			cr_sat = 24'sh7FFFFF;
		end else if (cr_w < -56'sd8388608) begin
			cr_sat = 24'sh800000;
		end else begin
			cr_sat = cr_w[COEF_W-1:0];
		end
		rp_sum = ((rop_q == 3'd3) ? 47'sd0 : rp_q) + prod_q[46:0];
		d_nxt  = (48'(mv_row) <<< 24) - 48'(rp_sum);
		bw     = ((kd_q + (64'sd1 <<< (23 + COORD_FRAC_BITS))) >>> (24 + COORD_FRAC_BITS))
			+ (64'(pv_row) <<< (12 - COORD_FRAC_BITS));
		priority if (bw > 64'sd2147483647) begin
			b_sat = 32'sh7FFFFFFF;
		end else if (bw < -64'sd2147483648) begin
			b_sat = 32'sh80000000;
		end else begin
			b_sat = bw[OFF_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DR_IDLE;
			ang_q   <= '0;
			step_q  <= '0;
			opi_q   <= '0;
			row_q   <= '0;
			rop_q   <= '0;
			for (int i = 0; i < 9; i++) begin
				coef_q.a[i] <= (i % 4 == 0) ? COEF_ONE : '0;
			end
			for (int i = 0; i < 3; i++) begin
				coef_q.b[i] <= '0;
			end
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				DR_IDLE: begin
					ang_q <= '0;
				end
				DR_ZINIT: begin
					step_q <= '0;
				end
				DR_ROT: begin
					step_q <= step_q + 1'b1;
				end
				DR_SAVE: begin
					ang_q <= ang_q + 1'b1;
					opi_q <= '0;
				end
				DR_MAT_ACC: begin
					opi_q <= opi_q + 1'b1;
					row_q <= '0;
					rop_q <= '0;
				end
				DR_ROW_ACC: begin
					rop_q <= rop_q + 1'b1;
					if (rop_q < 3'd3) begin
						coef_q.a[ridx] <= cr_sat;
					end
				end
				DR_ROW_END: begin
					coef_q.b[row_q] <= b_sat;
					row_q <= row_q + 1'b1;
					rop_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			DR_REDUCE: begin
				r_q    <= red_r[14:0];
				flip_q <= red_flip;
			end
			DR_ZINIT: begin
				z_q <= CORD_W'(r_q) * CORD_W'(DEG_TO_RAD);
				x_q <= CORDIC_GAIN;
				y_q <= '0;
			end
			DR_ROT: begin
				if (!z_q[CORD_W-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			DR_SAVE: begin
				trig_q[{ang_q, 1'b0}] <= sn_v;
				trig_q[{ang_q, 1'b1}] <= cs_v;
			end
			DR_MAT_MUL, DR_ROW_MUL: begin
				prod_q <= mul_a * mul_b;
				if (state_q == DR_MAT_MUL && opi_q == 4'd0) begin
					rm_q[3] <= trig_q[TRIG_SC];
				end
			end
			DR_MAT_ACC: begin
				if (mop.to_trig) begin
					trig_q[{2'b11, mop.dst[0]}] <= mat_v;
				end else begin
					unique case (mop.mode)
						ACC_SET: rm_q[mop.dst] <= mat_v;
						ACC_ADD: rm_q[mop.dst] <= rm_q[mop.dst] + mat_v;
						ACC_SUB: rm_q[mop.dst] <= rm_q[mop.dst] - mat_v;
						ACC_NEG: rm_q[mop.dst] <= -mat_v;
						default: rm_q[mop.dst] <= mat_v;
					endcase
				end
			end
			DR_ROW_ACC: begin
				if (rop_q >= 3'd3 && rop_q < 3'd6) begin
					rp_q <= rp_sum;
					if (rop_q == 3'd5) begin
						d_q <= d_nxt;
					end
				end else if (rop_q == 3'd6) begin
					kd_q <= 64'(prod_q);
				end else if (rop_q == 3'd7) begin
					kd_q <= (64'(prod_q) <<< 21) + kd_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign coef = coef_q;

endmodule

/* rtl/esp_vtx.sv */
`timescale 1ns / 1ps
module esp_vtx #(
	parameter int COORD_FRAC_BITS = esp_pkg::COORD_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  esp_pkg::coef_t      coef,
	input  logic                hold,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [15:0]  vx,
	input  logic signed [15:0]  vy,
	input  logic signed [15:0]  vz,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  ox,
	output logic signed [15:0]  oy,
	output logic signed [15:0]  oz,
	output logic                oclip
);
	import esp_pkg::*;

	localparam int ACC_W = 50;

	logic valid_s1, valid_s2, valid_s3;
	logic en1, en2, en3, take;

	assign en3      = !valid_s3 || !out_stall;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_stall = hold || !en1;
	assign take     = in_valid && !in_stall;

	logic signed [39:0]      prod_s1 [9];
	logic signed [ACC_W-1:0] acc_s2 [3];
	logic signed [15:0]      res_s3 [3];
	logic                    clip_s3;

	logic signed [15:0] vin [3];
	assign vin[0] = vx;
	assign vin[1] = vy;
	assign vin[2] = vz;

	logic signed [ACC_W-1:0] sh [3];
	logic signed [15:0]      sat_v [3];
	logic [2:0]              hit;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sh[r] = (acc_s2[r] + (50'sd1 <<< 15)) >>> 16;
			priority if (sh[r] > 50'sd32767) begin
				sat_v[r] = 16'sh7FFF;
				hit[r]   = 1'b1;
			end else if (sh[r] < -50'sd32768) begin
				sat_v[r] = 16'sh8000;
				hit[r]   = 1'b1;
			end else begin
				sat_v[r] = sh[r][15:0];
				hit[r]   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= take;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			for (int i = 0; i < 9; i++) begin
				prod_s1[i] <= $signed(coef.a[i]) * vin[i % 3];
			end
		end
		if (valid_s1 && en2) begin
			for (int r = 0; r < 3; r++) begin
				acc_s2[r] <= (ACC_W'($signed(coef.b[r])) <<< (4 + COORD_FRAC_BITS))
					+ ACC_W'(prod_s1[3*r]) + ACC_W'(prod_s1[3*r+1])
					+ ACC_W'(prod_s1[3*r+2]);
			end
		end
		if (valid_s2 && en3) begin
			for (int r = 0; r < 3; r++) begin
				res_s3[r] <= sat_v[r];
			end
			clip_s3 <= |hit;
		end
	end

	assign out_valid = valid_s3;
	assign ox        = res_s3[0];
	assign oy        = res_s3[1];
	assign oz        = res_s3[2];
	assign oclip     = clip_s3;

endmodule

/* rtl/euler_scale_pivot_affine_transform.sv */
`timescale 1ns / 1ps
// Channel   | Direction | Handshake            | Payload
// vertex    | in        | vertex_valid/_stall  | vertex_x, vertex_y, vertex_z (Q12.4)
// moved     | out       | moved_valid/_stall   | moved_x, moved_y, moved_z, clipped
// cfg       | in        | cfg_valid/cfg_ready  | cfg_index (3b), cfg_data (48b)
//
// Vertex path: three register stages (products, row sums, round and saturate),
// one item per cycle while vertex_stall is low; moved_valid rises once an item
// has passed through all three. A stall on the output backs up stage by stage;
// empty stages still fill. A config write to one of the four registers triggers
// coefficient derivation on a single shared 28x28 multiplier and CORDIC (steps
// capped at 24), during which cfg_ready is low and vertex_stall is high.
// Reset gives identity coefficients and zero offset.
module euler_scale_pivot_affine_transform #(
	parameter int COORD_FRAC_BITS = esp_pkg::COORD_FRAC_BITS_DEF,
	parameter int CORDIC_STEPS    = esp_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          vertex_valid,
	output logic                          vertex_stall,
	input  logic signed [15:0]            vertex_x,
	input  logic signed [15:0]            vertex_y,
	input  logic signed [15:0]            vertex_z,
	output logic                          moved_valid,
	input  logic                          moved_stall,
	output logic signed [15:0]            moved_x,
	output logic signed [15:0]            moved_y,
	output logic signed [15:0]            moved_z,
	output logic                          clipped,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [esp_pkg::CIDX_W-1:0]    cfg_index,
	input  logic [esp_pkg::REG_W-1:0]     cfg_data
);
	import esp_pkg::*;

	cfg_regs_t regs_q;
	coef_t     coef;
	logic      busy;
	logic      cfg_wr, start_q;

	assign cfg_ready = !busy && !start_q;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// register file; an index past the last register is dropped silently
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.move  <= '0;
			regs_q.angle <= '0;
			regs_q.scale <= SCALE_RESET;
			regs_q.pivot <= '0;
			start_q      <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_MOVE:  begin regs_q.move  <= cfg_data; start_q <= 1'b1; end
					REG_ANGLE: begin regs_q.angle <= cfg_data; start_q <= 1'b1; end
					REG_SCALE: begin regs_q.scale <= cfg_data; start_q <= 1'b1; end
					REG_PIVOT: begin regs_q.pivot <= cfg_data; start_q <= 1'b1; end
					default:   start_q <= 1'b0;
				endcase
			end
		end
	end

	esp_derive #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS),
		.CORDIC_STEPS   (CORDIC_STEPS)
	) u_derive (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start_q),
		.regs  (regs_q),
		.busy  (busy),
		.coef  (coef)
	);

	esp_vtx #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_vtx (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.hold     (busy || start_q),
		.in_valid (vertex_valid),
		.in_stall (vertex_stall),
		.vx       (vertex_x),
		.vy       (vertex_y),
		.vz       (vertex_z),
		.out_valid(moved_valid),
		.out_stall(moved_stall),
		.ox       (moved_x),
		.oy       (moved_y),
		.oz       (moved_z),
		.oclip    (clipped)
	);

endmodule
